### rtl/core/tpm_pkg.sv
package tpm_pkg;

    localparam int CHANNELS    = 2;
    localparam int TAIL_LEN    = 24;
    localparam int PHASES      = 4;
    localparam int SAMPLE_BITS = 24;

    localparam int NTAPS       = TAIL_LEN + 1;
    localparam int CH_W        = 1;
    localparam int IDX_W       = $clog2(NTAPS);
    localparam int PH_W        = $clog2(PHASES);
    localparam int ADDR_W      = CH_W + IDX_W;
    localparam int HIST_DEPTH  = 1 << ADDR_W;

    localparam int COEF_W      = 19;
    localparam int PROD_W      = SAMPLE_BITS + COEF_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int FRAC_SHIFT  = 17;
    localparam int RND_W       = ACC_W - FRAC_SHIFT;
    localparam int PEAK_W      = 25;
    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    localparam int PC_W        = 4;

    // Q1.17 interpolation taps, tap 0 multiplies the incoming sample
    localparam int COEF_TAB [PHASES][NTAPS] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 131072,
          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -1, 7, -39, 151, -475, 1266, -2966, 6387, -13687, 37865,
          117508, -21227, 9280, -4382, 1964, -790, 274, -79, 18, -3, 0, 0, 0},
        '{0, 0, -2, 16, -78, 289, -871, 2239, -5110, 10882, -23871, 82042,
          82042, -23871, 10882, -5110, 2239, -871, 289, -78, 16, -2, 0, 0, 0},
        '{0, 0, -3, 18, -79, 274, -790, 1964, -4382, 9280, -21227, 117508,
          37865, -13687, 6387, -2966, 1266, -475, 151, -39, 7, -1, 0, 0, 0}
    };

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_RESET = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_MAC,
        UOP_NOP,
        UOP_WRITE,
        UOP_OUT,
        UOP_CLEAR,
        UOP_RESET
    } uop_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_GOTO,
        BR_LOOP,
        BR_DISPATCH,
        BR_WAIT_OUT
    } br_t;

    typedef struct packed {
        uop_t            op;
        br_t             br;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] PC_MAC   = 4'd1;
    localparam logic [PC_W-1:0] PC_DRAIN = 4'd2;
    localparam logic [PC_W-1:0] PC_WRITE = 4'd6;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd7;
    localparam logic [PC_W-1:0] PC_CLEAR = 4'd8;
    localparam logic [PC_W-1:0] PC_RESET = 4'd9;

    typedef struct packed {
        logic             issue;
        logic [PH_W-1:0]  phase;
        logic [IDX_W-1:0] tap;
        logic             hist_write;
        logic             peak_clear;
        logic             hist_reset;
    } tpm_ctrl_t;

    // Control store: four drain steps let the last tap reach the peak latch
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uw;
        unique case (pc)
            PC_WAIT:      uw = '{UOP_WAIT,  BR_DISPATCH, PC_WAIT};
            PC_MAC:       uw = '{UOP_MAC,   BR_LOOP,     PC_MAC};
            PC_DRAIN,
            4'd3,
            4'd4,
            4'd5:         uw = '{UOP_NOP,   BR_NEXT,     PC_WAIT};
            PC_WRITE:     uw = '{UOP_WRITE, BR_GOTO,     PC_OUT};
            PC_OUT:       uw = '{UOP_OUT,   BR_WAIT_OUT, PC_WAIT};
            PC_CLEAR:     uw = '{UOP_CLEAR, BR_GOTO,     PC_OUT};
            PC_RESET:     uw = '{UOP_RESET, BR_GOTO,     PC_OUT};
            default:      uw = '{UOP_NOP,   BR_GOTO,     PC_WAIT};
        endcase
        return uw;
    endfunction

    function automatic logic [PC_W-1:0] dispatch(input opcode_t op, input logic chan_ok);
        logic [PC_W-1:0] pc;
        unique case (op)
            OP_PUSH:  pc = chan_ok ? PC_MAC : PC_OUT;
            OP_CLEAR: pc = PC_CLEAR;
            OP_RESET: pc = PC_RESET;
            OP_READ:  pc = PC_OUT;
            default:  pc = PC_OUT;
        endcase
        return pc;
    endfunction

endpackage

### rtl/core/tpm_seq.sv
module tpm_seq
    import tpm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [1:0]      s_opcode,
    input  logic            chan_ok,
    input  logic            out_free,
    output logic            s_ready,
    output logic            out_load,
    output tpm_ctrl_t       ctrl
);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [IDX_W-1:0] tap_reg, tap_next;
    ucode_t           uw;
    logic             accept;
    logic             tap_end;
    logic             all_done;

    assign uw       = ucode_rom(pc_reg);
    assign accept   = s_valid && (uw.op == UOP_WAIT);
    assign tap_end  = (tap_reg == IDX_W'(NTAPS - 1));
    assign all_done = tap_end && (phase_reg == PH_W'(PHASES - 1));

    always_comb begin
        s_ready         = (uw.op == UOP_WAIT);
        out_load        = (uw.op == UOP_OUT) && out_free;
        ctrl.issue      = (uw.op == UOP_MAC);
        ctrl.phase      = phase_reg;
        ctrl.tap        = tap_reg;
        ctrl.hist_write = (uw.op == UOP_WRITE);
        ctrl.peak_clear = (uw.op == UOP_CLEAR) || (uw.op == UOP_RESET);
        ctrl.hist_reset = (uw.op == UOP_RESET);

        unique case (uw.br)
            BR_NEXT:     pc_next = pc_reg + 1'b1;
            BR_GOTO:     pc_next = uw.target;
            BR_LOOP:     pc_next = all_done ? pc_reg + 1'b1 : uw.target;
            BR_DISPATCH: pc_next = accept ? dispatch(opcode_t'(s_opcode), chan_ok) : pc_reg;
            BR_WAIT_OUT: pc_next = out_free ? uw.target : pc_reg;
            default:     pc_next = PC_WAIT;
        endcase

        phase_next = phase_reg;
        tap_next   = tap_reg;
        if (accept) begin
            phase_next = '0;
            tap_next   = '0;
        end else if (ctrl.issue) begin
            // advance through the taps of one phase, then the next phase
            if (tap_end) begin
                tap_next   = '0;
                phase_next = phase_reg + 1'b1;
            end else begin
                tap_next = tap_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= PC_WAIT;
            phase_reg <= '0;
            tap_reg   <= '0;
        end else begin
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

### rtl/core/tpm_mac.sv
module tpm_mac
    import tpm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tpm_ctrl_t                     ctrl,
    input  logic [CH_W-1:0]               ch,
    input  logic signed [SAMPLE_BITS-1:0] x,
    output logic [PEAK_W-1:0]             peak_sel
);

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic use_x;
    } tap_tag_t;

    logic [SAMPLE_BITS-1:0]        hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]         hist_vld_reg;
    logic [IDX_W-1:0]              wp_reg [CHANNELS];

    logic [IDX_W:0]                idx_sum;
    logic [IDX_W-1:0]              rd_idx;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;

    logic [SAMPLE_BITS-1:0]        rdata_reg;
    logic                          rvld_reg;
    logic signed [COEF_W-1:0]      coef_reg;
    tap_tag_t                      s1_reg;
    tap_tag_t                      s2_reg;
    logic signed [SAMPLE_BITS-1:0] operand;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          s3_last_reg;
    logic [ACC_W-1:0]              acc_abs;
    logic [ACC_W-1:0]              acc_rnd;
    logic [RND_W-1:0]              rnd_reg;
    logic                          s4_reg;
    logic [PEAK_W-1:0]             mag_sat;
    logic [PEAK_W-1:0]             peak_reg [CHANNELS];

    // tap m reads the m-th newest stored sample of the channel
    always_comb begin
        idx_sum = (IDX_W + 1)'(wp_reg[ch]) + (IDX_W + 1)'(TAIL_LEN) - (IDX_W + 1)'(ctrl.tap);
        if (idx_sum >= (IDX_W + 1)'(TAIL_LEN)) begin
            idx_sum = idx_sum - (IDX_W + 1)'(TAIL_LEN);
        end
        rd_idx  = idx_sum[IDX_W-1:0];
        rd_addr = {ch, rd_idx};
        wr_addr = {ch, wp_reg[ch]};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            rdata_reg <= hist_mem[rd_addr];
        end
        if (ctrl.hist_write) begin
            hist_mem[wr_addr] <= x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                wp_reg[c] <= '0;
            end
        end else if (ctrl.hist_reset) begin
            hist_vld_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                wp_reg[c] <= '0;
            end
        end else if (ctrl.hist_write) begin
            hist_vld_reg[wr_addr] <= 1'b1;
            wp_reg[ch] <= (wp_reg[ch] == IDX_W'(TAIL_LEN - 1)) ? '0 : wp_reg[ch] + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rvld_reg <= hist_vld_reg[rd_addr];
        coef_reg <= COEF_W'(COEF_TAB[ctrl.phase][ctrl.tap]);
    end

    // never-written entries read as zero
    assign operand = s1_reg.use_x ? x :
                     (rvld_reg ? $signed(rdata_reg) : '0);

    always_ff @(posedge aclk) begin
        prod_reg <= operand * coef_reg;
        if (s2_reg.vld) begin
            acc_reg <= s2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (s3_last_reg) begin
            rnd_reg <= acc_rnd[ACC_W-1:FRAC_SHIFT];
        end
    end

    // round half up to Q2.23
    always_comb begin
        acc_abs = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        acc_rnd = acc_abs + (ACC_W'(1) << (FRAC_SHIFT - 1));
        mag_sat = (rnd_reg[RND_W-1:PEAK_W] != '0) ? PEAK_MAX : rnd_reg[PEAK_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg      <= '0;
            s2_reg      <= '0;
            s3_last_reg <= 1'b0;
            s4_reg      <= 1'b0;
        end else begin
            s1_reg.vld   <= ctrl.issue;
            s1_reg.first <= (ctrl.tap == '0);
            s1_reg.last  <= (ctrl.tap == IDX_W'(NTAPS - 1));
            s1_reg.use_x <= (ctrl.tap == '0);
            s2_reg       <= s1_reg;
            s3_last_reg  <= s2_reg.vld && s2_reg.last;
            s4_reg       <= s3_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                peak_reg[c] <= '0;
            end
        end else if (ctrl.peak_clear) begin
            for (int c = 0; c < CHANNELS; c++) begin
                peak_reg[c] <= '0;
            end
        end else if (s4_reg && (mag_sat > peak_reg[ch])) begin
            peak_reg[ch] <= mag_sat;
        end
    end

    assign peak_sel = peak_reg[ch];

endmodule

### rtl/core/true_peak_oversampling_meter.sv
// True-peak meter with 4x polyphase interpolation and one peak latch per channel.
// Input channel (s_valid/s_ready): opcode, channel, sample. Opcode push filters
// the sample against that channel's history, raises the latch and stores the
// sample; clear zeroes all latches; reset zeroes latches and history; read only
// reports. Every accepted item gives exactly one result item on the m_ channel:
// the channel and its latch after the update.
// A microcoded sequencer runs one multiply-accumulate per cycle through the
// 100 taps (4 phases x 25), followed by a pipeline drain, a history write
// and the result load. A new item is taken only after the program of the
// previous one has ended. The single MAC unit and the one-read-per-cycle
// history memory set the pace of a push through this program.
// s_ready is high only while the sequencer waits for an item. The result sits
// in an output register; the next item is still taken while it waits, and the
// sequencer holds at its result step only if a new result finds it not taken.
// Reset (aresetn low, synchronous) clears latches, history and all control.
module true_peak_oversampling_meter
    import tpm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_opcode,
    input  logic [CH_W-1:0]               s_channel,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CH_W-1:0]               m_channel_out,
    output logic [PEAK_W-1:0]             m_peak_latch
);

    tpm_ctrl_t                     ctrl;
    logic                          out_load;
    logic                          out_free;
    logic                          s_chan_ok;
    logic                          ch_ok;
    logic [CH_W-1:0]               ch_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [PEAK_W-1:0]             peak_sel;
    logic                          m_valid_reg;
    logic [CH_W-1:0]               m_channel_out_reg;
    logic [PEAK_W-1:0]             m_peak_latch_reg;

    assign s_chan_ok = (32'(s_channel) < CHANNELS);
    assign ch_ok     = (32'(ch_reg) < CHANNELS);
    assign out_free  = !m_valid_reg || m_ready;

    tpm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .chan_ok  (s_chan_ok),
        .out_free (out_free),
        .s_ready  (s_ready),
        .out_load (out_load),
        .ctrl     (ctrl)
    );

    tpm_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .ch       (ch_reg),
        .x        (sample_reg),
        .peak_sel (peak_sel)
    );

    // hold the item for the whole program
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg     <= s_channel;
            sample_reg <= s_sample;
        end
        if (out_load) begin
            m_channel_out_reg <= ch_reg;
            m_peak_latch_reg  <= ch_ok ? peak_sel : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_peak_latch  = m_peak_latch_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tpm_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int TAP_COUNT   = TAIL_LEN + 1;
    localparam longint LEVEL_CEIL = (longint'(1) << PEAK_W) - 1;
    localparam logic signed [SAMPLE_BITS-1:0] FS_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] FS_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Q1.17 interpolation taps; tap 0 weighs the incoming sample, tap m the
    // m-th most recent stored sample
    localparam int INTERP_TAPS [PHASES][TAP_COUNT] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 131072,
          0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, -1, 7, -39, 151, -475, 1266, -2966, 6387, -13687, 37865,
          117508, -21227, 9280, -4382, 1964, -790, 274, -79, 18, -3, 0, 0, 0},
        '{0, 0, -2, 16, -78, 289, -871, 2239, -5110, 10882, -23871, 82042,
          82042, -23871, 10882, -5110, 2239, -871, 289, -78, 16, -2, 0, 0, 0},
        '{0, 0, -3, 18, -79, 274, -790, 1964, -4382, 9280, -21227, 117508,
          37865, -13687, 6387, -2966, 1266, -475, 151, -39, 7, -1, 0, 0, 0}
    };

    typedef struct {
        logic [CH_W-1:0]   chan;
        logic [PEAK_W-1:0] level;
    } peak_report_t;

    class peak_scoreboard;
        // tail[c][0] is the newest stored sample of channel c
        logic signed [SAMPLE_BITS-1:0] tail [CHANNELS][TAIL_LEN];
        logic [PEAK_W-1:0]             level [CHANNELS];
        peak_report_t                  reports [$];
        int                            errors;

        function new();
            wipe(1'b0);
            errors = 0;
        endfunction

        function void wipe(bit levels_only);
            for (int c = 0; c < CHANNELS; c++) begin
                level[c] = '0;
                if (!levels_only) begin
                    for (int k = 0; k < TAIL_LEN; k++)
                        tail[c][k] = '0;
                end
            end
        endfunction

        function logic [PEAK_W-1:0] phase_level(int ch, int ph,
                                                logic signed [SAMPLE_BITS-1:0] x);
            longint acc;
            longint mag;
            acc = longint'(INTERP_TAPS[ph][0]) * longint'(x);
            for (int m = 1; m < TAP_COUNT; m++)
                acc += longint'(INTERP_TAPS[ph][m]) * longint'(tail[ch][m-1]);
            mag = (acc < 0) ? -acc : acc;
            // round half up from Q.40 down to Q2.23, then clamp
            mag = (mag + (longint'(1) << 16)) >> 17;
            if (mag > LEVEL_CEIL)
                mag = LEVEL_CEIL;
            return mag[PEAK_W-1:0];
        endfunction

        function void note_input(opcode_t op, logic [CH_W-1:0] ch,
                                 logic signed [SAMPLE_BITS-1:0] x);
            peak_report_t rpt;
            logic [PEAK_W-1:0] lvl;
            case (op)
                OP_PUSH: begin
                    if (ch < CHANNELS) begin
                        for (int ph = 0; ph < PHASES; ph++) begin
                            lvl = phase_level(int'(ch), ph, x);
                            if (lvl > level[ch])
                                level[ch] = lvl;
                        end
                        for (int k = TAIL_LEN - 1; k > 0; k--)
                            tail[ch][k] = tail[ch][k-1];
                        tail[ch][0] = x;
                    end
                end
                OP_CLEAR: wipe(1'b1);
                OP_RESET: wipe(1'b0);
                default: ;
            endcase
            rpt.chan  = ch;
            rpt.level = (ch < CHANNELS) ? level[ch] : '0;
            reports.push_back(rpt);
        endfunction

        function void check_result(logic [CH_W-1:0] ch, logic [PEAK_W-1:0] lvl);
            peak_report_t rpt;
            if (reports.size() == 0) begin
                $error("result item with nothing expected: channel_out %0d, peak_latch %0d",
                       ch, lvl);
                errors++;
                return;
            end
            rpt = reports.pop_front();
            if (ch !== rpt.chan) begin
                $error("channel_out: expected %0d, got %0d", rpt.chan, ch);
                errors++;
            end
            if (lvl !== rpt.level) begin
                $error("peak_latch: expected %0d, got %0d", rpt.level, lvl);
                errors++;
            end
        endfunction

        function int outstanding();
            return reports.size();
        endfunction
    endclass

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_opcode      = OP_READ;
    logic [CH_W-1:0]               s_channel     = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample      = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [CH_W-1:0]               m_channel_out;
    logic [PEAK_W-1:0]             m_peak_latch;

    peak_scoreboard sb = new();
    int             items_sent = 0;

    always #10 aclk = ~aclk;

    true_peak_oversampling_meter u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_peak_latch  (m_peak_latch)
    );

    // check results before noting new items so a same-edge accept never
    // lands in front of the expectation it should follow
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_channel_out, m_peak_latch);
            if (s_valid && s_ready)
                sb.note_input(opcode_t'(s_opcode), s_channel, s_sample);
        end
    end

    task automatic send_item(opcode_t op, logic [CH_W-1:0] ch,
                             logic signed [SAMPLE_BITS-1:0] x);
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_channel <= ch;
        s_sample  <= x;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            s_valid  <= 1'b0;
            s_sample <= SAMPLE_BITS'($urandom);
            repeat (n) @(posedge aclk);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int small_val;
        case ($urandom_range(0, 9))
            7: begin
                small_val = $urandom_range(0, 511);
                return SAMPLE_BITS'(small_val - 256);
            end
            8, 9: begin
                case ($urandom_range(0, 3))
                    0: return FS_POS;
                    1: return FS_NEG;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic opcode_t pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 84)
            return OP_PUSH;
        else if (r < 94)
            return OP_READ;
        else if (r < 97)
            return OP_CLEAR;
        else
            return OP_RESET;
    endfunction

    // one stretch of the result side: always ready, coin flip, mostly
    // stalled, or stalled throughout
    task automatic run_sink_segment(output int len);
        int mode;
        mode = $urandom_range(0, 3);
        len  = $urandom_range(1, 200);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 9) == 0);
                default: m_ready <= 1'b0;
            endcase
            @(posedge aclk);
        end
    endtask

    initial begin : result_sink
        int waited;
        int seg_len;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        waited = 0;
        while (waited < 6000) begin
            run_sink_segment(seg_len);
            waited += seg_len;
        end
        // long hold-off: let the block back up into its input
        m_ready <= 1'b0;
        repeat (4000) @(posedge aclk);
        forever run_sink_segment(seg_len);
    end

    initial begin : stimulus
        int burst_len;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty latches, full-scale steps, ringing from alternation
        send_item(OP_READ, 1'b0, FS_NEG);
        send_item(OP_READ, 1'b1, FS_POS);
        send_item(OP_PUSH, 1'b0, FS_POS);
        send_item(OP_PUSH, 1'b0, FS_NEG);
        for (int i = 0; i < 8; i++)
            send_item(OP_PUSH, 1'b1, i[0] ? FS_NEG : FS_POS);
        send_item(OP_READ, 1'b1, 24'h5a5a5a);
        send_item(OP_CLEAR, 1'b1, FS_POS);
        send_item(OP_READ, 1'b0, '0);
        send_item(OP_PUSH, 1'b0, '0);
        send_item(OP_PUSH, 1'b0, 24'sd1);
        send_item(OP_PUSH, 1'b0, -24'sd1);
        send_item(OP_READ, 1'b0, '1);
        send_item(OP_RESET, 1'b0, FS_NEG);
        send_item(OP_READ, 1'b1, '0);
        send_item(OP_PUSH, 1'b1, -24'sd1);
        send_item(OP_READ, 1'b0, '0);

        // random bursts with gaps of every length up to a full push
        while (items_sent < ITEM_TARGET) begin
            burst_len = $urandom_range(1, 12);
            for (int i = 0; i < burst_len; i++)
                send_item(pick_opcode(), CH_W'($urandom_range(0, 1)), pick_sample());
            if ($urandom_range(0, 5) == 0)
                idle_for($urandom_range(1, 120));
            else
                idle_for($urandom_range(0, 3));
        end
        s_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);

        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/core/tpm_pkg.sv
rtl/core/tpm_seq.sv
rtl/core/tpm_mac.sv
rtl/core/true_peak_oversampling_meter.sv
tb/tb_top.sv
